// ===== rtl/cpel_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpel_pkg
// Shared types and codes for the capture period event logger.
// ----------------------------------------------------------------------------
package cpel_pkg;

   typedef enum logic [1:0] {
      OP_OVERFLOW = 2'd0,
      OP_CAPTURE  = 2'd1,
      OP_POP      = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic {
      KIND_CAPTURE  = 1'b0,
      KIND_OVERFLOW = 1'b1
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [10:0] backlog;
      logic [63:0] period;
      logic [63:0] timestamp;
      logic [31:0] aux_count;
      logic [15:0] main_count;
      logic [31:0] overflows;
      logic        kind;
      logic [31:0] id;
   } record_type;

   localparam int RECORD_W = $bits(record_type);

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_cmd_type;

   typedef struct packed {
      logic        empty;
      logic [10:0] occupancy;
      logic [31:0] dropped;
      logic [9:0]  peak;
   } fifo_status_type;

endpackage

// ===== rtl/capture_period_event_logger.sv =====
`timescale 1ns / 1ps
// Timing: rsp_tvalid is registered from the execute state that follows acceptance,
// and the RAM read and timestamp product are registered at acceptance.
// Flow: no new item is taken until the read-then-execute pass through the record RAM
// is done, and the execute state holds while the result register is not taken.
// Reset: synchronous; counters, pointers and reload (to 65535) are set, the
// record RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// capture_period_event_logger
// Timer capture period measurement with an event record FIFO.
// ----------------------------------------------------------------------------
module capture_period_event_logger #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   // csr write channel: reload_value
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data,
   // req_tuser: operation[1:0]
   // req_tdata: captured_value[15:0], live_count_main[31:16], live_count_aux[63:32]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   // rsp_tuser: record_valid[0], record_kind[1]
   // rsp_tdata: record_id[31:0], record_overflows[63:32], record_main_count[79:64],
   //   record_aux_count[111:80], record_timestamp[175:112], record_period[239:176],
   //   record_backlog[250:240], occupancy[261:251], dropped_count[293:262],
   //   peak_pending[303:294]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [303:0] rsp_tdata,
   output logic [1:0]   rsp_tuser
);

   import cpel_pkg::*;

   logic [15:0]  reload_ff;
   logic [31:0]  ovf_ff;
   logic [63:0]  prev_ts_ff;
   logic [31:0]  seq_ff;
   state_type    state_ff, state_in;
   op_type       op_ff;
   logic [15:0]  cap_ff;
   logic [15:0]  main_ff;
   logic [31:0]  aux_ff;
   logic [48:0]  prod_ff;
   logic         rsp_valid_ff;
   logic [1:0]   rsp_user_ff;
   logic [303:0] rsp_data_ff;

   logic            req_fire, out_free, done, is_event, rec_valid;
   logic [63:0]     ts, per;
   logic [31:0]     ovf_inc;
   fifo_cmd_type    cmd;
   record_type      wr_record, rd_record, out_record;
   fifo_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= 16'hFFFF;
      end else if (csr_valid && csr_ready) begin
         reload_ff <= csr_data;
      end
   end

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign done     = (state_ff == ST_EXEC) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // item capture and timestamp product
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= op_type'(req_tuser);
         cap_ff  <= req_tdata[15:0];
         main_ff <= req_tdata[31:16];
         aux_ff  <= req_tdata[63:32];
         prod_ff <= ovf_ff * ({1'b0, reload_ff} + 17'd1);
      end
   end

   assign ts       = 64'(prod_ff) + 64'(cap_ff);
   assign per      = ts - prev_ts_ff;
   assign ovf_inc  = ovf_ff + 32'd1;
   assign is_event = (op_ff == OP_OVERFLOW) || (op_ff == OP_CAPTURE);

   assign cmd.push = done && is_event;
   assign cmd.pop  = done && (op_ff == OP_POP);

   always_comb begin
      wr_record            = '0;
      wr_record.id         = seq_ff;
      wr_record.main_count = main_ff;
      wr_record.aux_count  = aux_ff;
      if (op_ff == OP_OVERFLOW) begin
         wr_record.kind      = KIND_OVERFLOW;
         wr_record.overflows = ovf_inc;
      end else begin
         wr_record.kind      = KIND_CAPTURE;
         wr_record.overflows = ovf_ff;
         wr_record.timestamp = ts;
         wr_record.period    = per;
      end
   end

   cpel_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire && (op_type'(req_tuser) == OP_POP)),
      .cmd       (cmd),
      .wr_record (wr_record),
      .rd_record (rd_record),
      .status    (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff     <= '0;
         prev_ts_ff <= '0;
         seq_ff     <= '0;
      end else if (done) begin
         if (is_event) begin
            seq_ff <= seq_ff + 32'd1;
         end
         if (op_ff == OP_OVERFLOW) begin
            ovf_ff <= ovf_inc;
         end
         if (op_ff == OP_CAPTURE) begin
            prev_ts_ff <= ts;
         end
      end
   end

   assign rec_valid  = (op_ff == OP_POP) && !status.empty;
   assign out_record = rec_valid ? rd_record : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_user_ff <= {out_record.kind, rec_valid};
         rsp_data_ff <= {status.peak, status.dropped, status.occupancy,
                         out_record.backlog, out_record.period, out_record.timestamp,
                         out_record.aux_count, out_record.main_count,
                         out_record.overflows, out_record.id};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted item not executed");

   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      done && is_event |=> seq_ff == $past(seq_ff) + 32'd1)
      else $error("sequence number did not advance on event");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("result without an executed item");

   a_valid_only_pop: assert property (@(posedge clock) disable iff (reset)
      done && rec_valid |-> cmd.pop && !cmd.push)
      else $error("record returned outside a pop");

endmodule

// ===== rtl/cpel_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpel_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cpel_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpel_fifo
// Record FIFO: pointers, occupancy, drop counter, high-water mark, record RAM.
// ----------------------------------------------------------------------------
module cpel_fifo #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  cpel_pkg::fifo_cmd_type    cmd,
   input  cpel_pkg::record_type      wr_record,
   output cpel_pkg::record_type      rd_record,
   output cpel_pkg::fifo_status_type status
);

   import cpel_pkg::*;

   localparam int ADDR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       drop_ff, drop_in;
   logic [ADDR_W-1:0] peak_ff, peak_in;
   logic              full, empty, push_ok, pop_ok;
   record_type        ram_wdata;
   logic [RECORD_W-1:0] ram_rdata;

   assign full    = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = cmd.push && !full;
   assign pop_ok  = cmd.pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      peak_in   = peak_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
         if (count_ff > CNT_W'(peak_ff)) begin
            peak_in = ADDR_W'(count_ff);
         end
      end
      if (cmd.push && full) begin
         drop_in = drop_ff + 32'd1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         drop_ff   <= '0;
         peak_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         drop_ff   <= drop_in;
         peak_ff   <= peak_in;
      end
   end

   always_comb begin
      ram_wdata         = wr_record;
      ram_wdata.backlog = 11'(count_ff);
   end

   cpel_ram #(
      .WIDTH (RECORD_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   assign rd_record        = record_type'(ram_rdata);
   assign status.empty     = empty;
   assign status.occupancy = 11'(count_in);
   assign status.dropped   = drop_in;
   assign status.peak      = 10'(peak_in);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fifo occupancy above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      push_ok |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not raise occupancy");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(peak_ff) < CNT_W'(FIFO_DEPTH))
      else $error("high-water mark out of range");

endmodule
